// File: rtl/core/hrlp_pkg.sv
// -----------------------------------------------------------------------------
// hrlp_pkg
// Types, codes and character helpers shared by the request line parser.
// -----------------------------------------------------------------------------
package hrlp_pkg;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_PATH    = 3'd1,
      PH_QUERY   = 3'd2,
      PH_VERSION = 3'd3,
      PH_IDLE    = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE      = 4'd0,
      EV_PATH      = 4'd1,
      EV_KEY       = 4'd2,
      EV_VAL       = 4'd3,
      EV_KEY_START = 4'd4,
      EV_VAL_START = 4'd5,
      EV_TGT_END   = 4'd6,
      EV_DONE      = 4'd7,
      EV_ERROR     = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_METHOD    = 3'd1,
      ERR_PATH_CHAR = 3'd2,
      ERR_TOO_LONG  = 3'd3,
      ERR_VERSION   = 3'd4,
      ERR_PARAMS    = 3'd5
   } error_type;

   localparam logic [2:0] METH_NONE   = 3'd0;
   localparam logic [2:0] METH_GET    = 3'd1;
   localparam logic [2:0] METH_PUT    = 3'd2;
   localparam logic [2:0] METH_POST   = 3'd3;
   localparam logic [2:0] METH_PATCH  = 3'd4;
   localparam logic [2:0] METH_DELETE = 3'd5;

   localparam logic [1:0] HEX_NONE = 2'd0;
   localparam logic [1:0] HEX_HIGH = 2'd1;
   localparam logic [1:0] HEX_LOW  = 2'd2;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PERCENT  = 8'h25;
   localparam logic [7:0] CH_AMP      = 8'h26;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_ZERO     = 8'h30;

   localparam logic [2:0] VER_MAJOR_POS = 3'd5;
   localparam logic [2:0] VER_DOT_POS   = 3'd6;
   localparam logic [2:0] VER_MINOR_POS = 3'd7;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  out_byte;
      logic [2:0]  method_code;
      logic [5:0]  param_index;
      logic [8:0]  path_length;
      error_type   err;
      logic [7:0]  version_major;
      logic [7:0]  version_minor;
   } rsp_type;

   function automatic logic [2:0] meth_len(input logic [2:0] cand);
      logic [2:0] len;
      case (cand)
         METH_GET:    len = 3'd4;
         METH_PUT:    len = 3'd4;
         METH_POST:   len = 3'd5;
         METH_PATCH:  len = 3'd6;
         METH_DELETE: len = 3'd7;
         default:     len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] meth_char(input logic [2:0] cand, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (cand)
         METH_GET: begin
            case (pos)
               3'd0:    ch = "G";
               3'd1:    ch = "E";
               3'd2:    ch = "T";
               3'd3:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         METH_PUT: begin
            case (pos)
               3'd0:    ch = "P";
               3'd1:    ch = "U";
               3'd2:    ch = "T";
               3'd3:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         METH_POST: begin
            case (pos)
               3'd0:    ch = "P";
               3'd1:    ch = "O";
               3'd2:    ch = "S";
               3'd3:    ch = "T";
               3'd4:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         METH_PATCH: begin
            case (pos)
               3'd0:    ch = "P";
               3'd1:    ch = "A";
               3'd2:    ch = "T";
               3'd3:    ch = "C";
               3'd4:    ch = "H";
               3'd5:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         METH_DELETE: begin
            case (pos)
               3'd0:    ch = "D";
               3'd1:    ch = "E";
               3'd2:    ch = "L";
               3'd3:    ch = "E";
               3'd4:    ch = "T";
               3'd5:    ch = "E";
               3'd6:    ch = " ";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] ver_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = "H";
         3'd1:    ch = "T";
         3'd2:    ch = "T";
         3'd3:    ch = "P";
         3'd4:    ch = "/";
         3'd6:    ch = ".";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Unchecked hex digit: fold lower case, then letters from 'A' up, else digits.
   function automatic logic [7:0] hex_value(input logic [7:0] b);
      logic [7:0] u;
      u = b;
      if (b >= 8'h61 && b <= 8'h7A) begin
         u = b - 8'h20;
      end
      return (u >= 8'h41) ? u - 8'h37 : u - 8'h30;
   endfunction

   function automatic logic path_char_ok(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A) || b == 8'h2F || b == 8'h2D ||
             b == 8'h2E || b == 8'h5F || b == 8'h7E;
   endfunction

endpackage

// File: rtl/core/hrlp_parse.sv
// -----------------------------------------------------------------------------
// hrlp_parse
// Parser state and the one-byte update: method match, path and query split,
// percent decoding and version check. Produces one response per byte.
// -----------------------------------------------------------------------------
module hrlp_parse
   import hrlp_pkg::*;
#(
   parameter int MAX_PATH   = 256,
   parameter int MAX_PARAMS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       line_start,
   output rsp_type    rsp
);

   localparam int TW = $clog2(MAX_PATH + 1);
   localparam int PW = $clog2(MAX_PARAMS + 1);

   phase_type       phase_ff, phase_in;
   logic [2:0]      mpos_ff, mpos_in;
   logic [2:0]      cand_ff, cand_in;
   logic [1:0]      hex_ff, hex_in;
   logic [7:0]      high_ff, high_in;
   logic [TW-1:0]   tidx_ff, tidx_in;
   logic [PW-1:0]   pcnt_ff, pcnt_in;
   logic            key_ff, key_in;
   logic [7:0]      major_ff, major_in;
   logic [8:0]      plen_ff, plen_in;

   // state as seen by this byte (line_start restarts the parser first)
   phase_type       s_phase;
   logic [2:0]      s_mpos, s_cand;
   logic [1:0]      s_hex;
   logic [7:0]      s_high, s_major;
   logic [TW-1:0]   s_tidx;
   logic [PW-1:0]   s_pcnt;
   logic            s_key;
   logic [8:0]      s_plen;

   logic [2:0]      cand_m;
   logic [2:0]      pos_inc;
   logic            meth_fail;
   logic            inq;
   logic            limit_hit;
   logic            is_term;
   logic            params_full;
   logic [7:0]      hexv;
   logic [7:0]      decoded;
   logic [8:0]      tidx9;
   logic [TW-1:0]   tidx_inc;
   logic [PW-1:0]   pcnt_dec;
   logic [PW+5:0]   pidx_wide;
   logic [TW+8:0]   tidx_wide;
   event_type       ev_data;

   assign s_phase = line_start ? PH_METHOD : phase_ff;
   assign s_mpos  = line_start ? 3'd0 : mpos_ff;
   assign s_cand  = line_start ? METH_NONE : cand_ff;
   assign s_hex   = line_start ? HEX_NONE : hex_ff;
   assign s_high  = line_start ? 8'd0 : high_ff;
   assign s_tidx  = line_start ? '0 : tidx_ff;
   assign s_pcnt  = line_start ? '0 : pcnt_ff;
   assign s_key   = line_start ? 1'b0 : key_ff;
   assign s_major = line_start ? 8'd0 : major_ff;
   assign s_plen  = line_start ? 9'd0 : plen_ff;

   always_comb begin
      cand_m = s_cand;
      if (s_mpos == 3'd0) begin
         if (in_byte == "G") begin
            cand_m = METH_GET;
         end else if (in_byte == "P") begin
            cand_m = METH_PUT;
         end else if (in_byte == "D") begin
            cand_m = METH_DELETE;
         end else begin
            cand_m = METH_NONE;
         end
      end else if (s_cand == METH_PUT && s_mpos == 3'd1) begin
         if (in_byte == "O") begin
            cand_m = METH_POST;
         end else if (in_byte == "A") begin
            cand_m = METH_PATCH;
         end
      end
   end

   // unknown candidates have length zero, so the position check rejects them
   assign meth_fail   = (s_mpos >= meth_len(cand_m)) || (meth_char(cand_m, s_mpos) != in_byte);
   assign pos_inc     = s_mpos + 3'd1;
   assign inq         = (s_phase == PH_QUERY);
   assign limit_hit   = inq ? (s_tidx >= TW'(MAX_PATH)) : (s_tidx >= TW'(MAX_PATH - 1));
   assign is_term     = (in_byte == CH_SPACE) || (!inq && in_byte == CH_NUL);
   assign params_full = (s_pcnt >= PW'(MAX_PARAMS));
   assign hexv        = hex_value(in_byte);
   assign decoded     = {s_high[3:0], 4'b0000} | hexv;
   assign tidx_inc    = s_tidx + TW'(1);
   assign tidx_wide   = {9'd0, s_tidx};
   assign tidx9       = tidx_wide[8:0];
   assign ev_data     = inq ? (s_key ? EV_KEY : EV_VAL) : EV_PATH;

   // next state
   always_comb begin
      phase_in = s_phase;
      mpos_in  = s_mpos;
      cand_in  = s_cand;
      hex_in   = s_hex;
      high_in  = s_high;
      tidx_in  = s_tidx;
      pcnt_in  = s_pcnt;
      key_in   = s_key;
      major_in = s_major;
      plen_in  = s_plen;
      case (s_phase)
         PH_METHOD: begin
            if (meth_fail) begin
               cand_in  = METH_NONE;
               phase_in = PH_IDLE;
            end else begin
               cand_in = cand_m;
               mpos_in = pos_inc;
               if (pos_inc == meth_len(cand_m)) begin
                  phase_in = PH_PATH;
                  mpos_in  = 3'd0;
               end
            end
         end
         PH_PATH, PH_QUERY: begin
            if (s_hex == HEX_HIGH) begin
               high_in = hexv;
               hex_in  = HEX_LOW;
            end else if (s_hex == HEX_LOW) begin
               hex_in  = HEX_NONE;
               tidx_in = tidx_inc;
            end else if (limit_hit) begin
               phase_in = PH_IDLE;
            end else if (is_term) begin
               if (!inq) begin
                  plen_in = tidx9;
               end
               phase_in = PH_VERSION;
               mpos_in  = 3'd0;
            end else if (in_byte == CH_PERCENT) begin
               hex_in = HEX_HIGH;
            end else if (!inq) begin
               if (in_byte == CH_QUESTION) begin
                  plen_in  = tidx9;
                  tidx_in  = tidx_inc;
                  pcnt_in  = PW'(1);
                  key_in   = 1'b1;
                  phase_in = PH_QUERY;
               end else if (path_char_ok(in_byte)) begin
                  tidx_in = tidx_inc;
               end else begin
                  phase_in = PH_IDLE;
               end
            end else if (in_byte == CH_EQUAL && s_key) begin
               key_in  = 1'b0;
               tidx_in = tidx_inc;
            end else if (in_byte == CH_AMP) begin
               if (params_full) begin
                  phase_in = PH_IDLE;
               end else begin
                  pcnt_in = s_pcnt + PW'(1);
                  key_in  = 1'b1;
                  tidx_in = tidx_inc;
               end
            end else begin
               tidx_in = tidx_inc;
            end
         end
         PH_VERSION: begin
            if (s_mpos == VER_MAJOR_POS) begin
               major_in = in_byte - CH_ZERO;
               mpos_in  = VER_DOT_POS;
            end else if (s_mpos == VER_MINOR_POS) begin
               phase_in = PH_IDLE;
            end else if (ver_char(s_mpos) != in_byte) begin
               phase_in = PH_IDLE;
            end else begin
               mpos_in = pos_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign pcnt_dec  = pcnt_in - PW'(1);
   assign pidx_wide = {6'd0, pcnt_dec};

   // response
   always_comb begin
      rsp.ev            = EV_NONE;
      rsp.out_byte      = 8'd0;
      rsp.err           = ERR_NONE;
      rsp.version_major = 8'd0;
      rsp.version_minor = 8'd0;
      rsp.method_code   = (phase_in == PH_METHOD) ? METH_NONE : cand_in;
      rsp.param_index   = (pcnt_in == '0) ? 6'd0 : pidx_wide[5:0];
      rsp.path_length   = plen_in;
      case (s_phase)
         PH_METHOD: begin
            if (meth_fail) begin
               rsp.ev  = EV_ERROR;
               rsp.err = ERR_METHOD;
            end
         end
         PH_PATH, PH_QUERY: begin
            if (s_hex == HEX_HIGH) begin
               rsp.ev = EV_NONE;
            end else if (s_hex == HEX_LOW) begin
               rsp.ev       = ev_data;
               rsp.out_byte = decoded;
            end else if (limit_hit) begin
               rsp.ev  = EV_ERROR;
               rsp.err = ERR_TOO_LONG;
            end else if (is_term) begin
               rsp.ev = EV_TGT_END;
            end else if (in_byte == CH_PERCENT) begin
               rsp.ev = EV_NONE;
            end else if (!inq) begin
               if (in_byte == CH_QUESTION) begin
                  rsp.ev = EV_KEY_START;
               end else if (path_char_ok(in_byte)) begin
                  rsp.ev       = EV_PATH;
                  rsp.out_byte = in_byte;
               end else begin
                  rsp.ev  = EV_ERROR;
                  rsp.err = ERR_PATH_CHAR;
               end
            end else if (in_byte == CH_EQUAL && s_key) begin
               rsp.ev = EV_VAL_START;
            end else if (in_byte == CH_AMP) begin
               if (params_full) begin
                  rsp.ev  = EV_ERROR;
                  rsp.err = ERR_PARAMS;
               end else begin
                  rsp.ev = EV_KEY_START;
               end
            end else begin
               rsp.ev       = ev_data;
               rsp.out_byte = in_byte;
            end
         end
         PH_VERSION: begin
            if (s_mpos == VER_MAJOR_POS) begin
               rsp.ev = EV_NONE;
            end else if (s_mpos == VER_MINOR_POS) begin
               rsp.ev            = EV_DONE;
               rsp.version_major = s_major;
               rsp.version_minor = in_byte - CH_ZERO;
            end else if (ver_char(s_mpos) != in_byte) begin
               rsp.ev  = EV_ERROR;
               rsp.err = ERR_VERSION;
            end
         end
         default: begin
            rsp.ev = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD;
         mpos_ff  <= 3'd0;
         cand_ff  <= METH_NONE;
         hex_ff   <= HEX_NONE;
         high_ff  <= 8'd0;
         tidx_ff  <= '0;
         pcnt_ff  <= '0;
         key_ff   <= 1'b0;
         major_ff <= 8'd0;
         plen_ff  <= 9'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         mpos_ff  <= mpos_in;
         cand_ff  <= cand_in;
         hex_ff   <= hex_in;
         high_ff  <= high_in;
         tidx_ff  <= tidx_in;
         pcnt_ff  <= pcnt_in;
         key_ff   <= key_in;
         major_ff <= major_in;
         plen_ff  <= plen_in;
      end
   end

endmodule

// File: rtl/core/hrlp_out_reg.sv
// -----------------------------------------------------------------------------
// hrlp_out_reg
// Response register: holds one response until the receiver takes it and
// lets a new one load in the same cycle as the old one leaves.
// -----------------------------------------------------------------------------
module hrlp_out_reg
   import hrlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// File: rtl/core/http_request_line_parser_core.sv
// -----------------------------------------------------------------------------
// http_request_line_parser_core
// HTTP request line parser, one byte in and one response out per request.
// -----------------------------------------------------------------------------
// Usage:
//   Feed the request line on the req_ stream, one byte per request, with
//   req_tuser high on the first byte of each line; that byte restarts the
//   parser. Every request yields exactly one response on the rsp_ stream:
//   an event code in rsp_tuser plus decoded byte, method, parameter index,
//   path length, error code and version digits in rsp_tdata.
//   The response is registered, so rsp_tvalid rises in the cycle after
//   acceptance; throughput is one request per cycle while the receiver
//   takes responses, as the state update feeds the response register.
//   After done or error the parser answers "none" until the next line start.
//   Reset returns the parser to method matching and empties the response
//   register. When the receiver stalls, the response register holds its
//   response and req_tready drops until rsp_tready returns.
// -----------------------------------------------------------------------------
module http_request_line_parser_core
   import hrlp_pkg::*;
#(
   parameter int MAX_PATH   = 256,
   parameter int MAX_PARAMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] line_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] out_byte, [10:8] method_code,
                                    // [16:11] param_index, [25:17] path_length,
                                    // [28:26] error_code, [36:29] version_major,
                                    // [44:37] version_minor, [47:45] zero
   output logic [3:0]  rsp_tuser    // [3:0] event_res
);

   rsp_type step_rsp;
   rsp_type out_rsp;
   logic    accept;

   assign accept = req_tvalid && req_tready;

   hrlp_parse #(
      .MAX_PATH   (MAX_PATH),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .in_byte    (req_tdata),
      .line_start (req_tuser),
      .rsp        (step_rsp)
   );

   hrlp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_rsp)
   );

   assign rsp_tuser = out_rsp.ev;
   assign rsp_tdata = {3'b000, out_rsp.version_minor, out_rsp.version_major, out_rsp.err,
                       out_rsp.path_length, out_rsp.param_index, out_rsp.method_code,
                       out_rsp.out_byte};

endmodule

// File: sim/http_request_line_parser_core_checker.sv
// -----------------------------------------------------------------------------
// http_request_line_parser_core_checker
// Watches both streams of the request line parser, runs its own parser on
// every accepted request and compares each response field by field.
// -----------------------------------------------------------------------------
module http_request_line_parser_core_checker
   import hrlp_pkg::*;
#(
   parameter int MAX_PATH   = 256,
   parameter int MAX_PARAMS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] line_start
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [7:0] out_byte, [10:8] method_code,
                                    // [16:11] param_index, [25:17] path_length,
                                    // [28:26] error_code, [36:29] version_major,
                                    // [44:37] version_minor, [47:45] zero
   input  logic [3:0]  rsp_tuser,   // [3:0] event_res
   output int          fail_count,
   output int          backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type  ph;
   int         mpos;
   logic [2:0] mcand;
   logic [1:0] hex_state;
   logic [7:0] high_digit;
   int         tgt_count;
   int         param_count;
   logic       key_open;
   logic [7:0] major_digit;
   int         path_chars;
   rsp_type    parsed_q[$];

   logic [7:0] version_text [8] = '{"H", "T", "T", "P", "/", 8'h00, ".", 8'h00};

   task automatic clear_parser();
      ph          = PH_METHOD;
      mpos        = 0;
      mcand       = METH_NONE;
      hex_state   = HEX_NONE;
      high_digit  = 8'h00;
      tgt_count   = 0;
      param_count = 0;
      key_open    = 1'b0;
      major_digit = 8'h00;
      path_chars  = 0;
   endtask

   function automatic string method_word(input logic [2:0] cand);
      case (cand)
         METH_GET:    return "GET ";
         METH_PUT:    return "PUT ";
         METH_POST:   return "POST ";
         METH_PATCH:  return "PATCH ";
         METH_DELETE: return "DELETE ";
         default:     return "";
      endcase
   endfunction

   // No range check: anything at or above 'A' counts as a letter digit.
   function automatic logic [7:0] nibble(input logic [7:0] b);
      logic [7:0] up;
      up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
      return (up >= "A") ? up - 8'd55 : up - CH_ZERO;
   endfunction

   function automatic logic url_safe(input logic [7:0] b);
      if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
         return 1'b1;
      end
      return b inside {"/", "-", ".", "_", "~"};
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic first, output rsp_type r);
      event_type  ev;
      event_type  dat;
      error_type  err;
      logic [7:0] ob;
      logic [7:0] vmaj;
      logic [7:0] vmin;
      logic       inq;
      int         pos;
      string      word;
      ev   = EV_NONE;
      err  = ERR_NONE;
      ob   = 8'h00;
      vmaj = 8'h00;
      vmin = 8'h00;
      if (first) begin
         clear_parser();
      end
      case (ph)
         PH_METHOD: begin
            pos = mpos;
            if (pos == 0) begin
               case (b)
                  "G":     mcand = METH_GET;
                  "P":     mcand = METH_PUT;
                  "D":     mcand = METH_DELETE;
                  default: mcand = METH_NONE;
               endcase
            end else if (mcand == METH_PUT && pos == 1) begin
               if (b == "O") begin
                  mcand = METH_POST;
               end else if (b == "A") begin
                  mcand = METH_PATCH;
               end
            end
            word = method_word(mcand);
            if (pos >= word.len() || word[pos] != b) begin
               mcand = METH_NONE;
               ev    = EV_ERROR;
               err   = ERR_METHOD;
               ph    = PH_IDLE;
            end else begin
               mpos = pos + 1;
               if (mpos == word.len()) begin
                  ph   = PH_PATH;
                  mpos = 0;
               end
            end
         end
         PH_PATH, PH_QUERY: begin
            inq = (ph == PH_QUERY);
            dat = inq ? (key_open ? EV_KEY : EV_VAL) : EV_PATH;
            if (hex_state == HEX_HIGH) begin
               high_digit = nibble(b);
               hex_state  = HEX_LOW;
            end else if (hex_state == HEX_LOW) begin
               ob        = {high_digit[3:0], 4'h0} | nibble(b);
               ev        = dat;
               hex_state = HEX_NONE;
               tgt_count++;
            end else if (tgt_count >= (inq ? MAX_PATH : MAX_PATH - 1)) begin
               ev  = EV_ERROR;
               err = ERR_TOO_LONG;
               ph  = PH_IDLE;
            end else if (b == CH_SPACE || (!inq && b == CH_NUL)) begin
               if (!inq) begin
                  path_chars = tgt_count;
               end
               ev   = EV_TGT_END;
               ph   = PH_VERSION;
               mpos = 0;
            end else if (b == CH_PERCENT) begin
               hex_state = HEX_HIGH;
            end else if (!inq) begin
               if (b == CH_QUESTION) begin
                  path_chars = tgt_count;
                  tgt_count++;
                  param_count = 1;
                  key_open    = 1'b1;
                  ev          = EV_KEY_START;
                  ph          = PH_QUERY;
               end else if (url_safe(b)) begin
                  ev = EV_PATH;
                  ob = b;
                  tgt_count++;
               end else begin
                  ev  = EV_ERROR;
                  err = ERR_PATH_CHAR;
                  ph  = PH_IDLE;
               end
            end else if (b == CH_EQUAL && key_open) begin
               key_open = 1'b0;
               tgt_count++;
               ev = EV_VAL_START;
            end else if (b == CH_AMP) begin
               if (param_count >= MAX_PARAMS) begin
                  ev  = EV_ERROR;
                  err = ERR_PARAMS;
                  ph  = PH_IDLE;
               end else begin
                  param_count++;
                  key_open = 1'b1;
                  tgt_count++;
                  ev = EV_KEY_START;
               end
            end else begin
               ev = dat;
               ob = b;
               tgt_count++;
            end
         end
         PH_VERSION: begin
            pos = mpos;
            if (pos == VER_MAJOR_POS) begin
               major_digit = b - CH_ZERO;
               mpos        = VER_DOT_POS;
            end else if (pos == VER_MINOR_POS) begin
               ev   = EV_DONE;
               vmaj = major_digit;
               vmin = b - CH_ZERO;
               ph   = PH_IDLE;
            end else if (version_text[pos] != b) begin
               ev  = EV_ERROR;
               err = ERR_VERSION;
               ph  = PH_IDLE;
            end else begin
               mpos = pos + 1;
            end
         end
         default: ph = PH_IDLE;
      endcase
      r.ev            = ev;
      r.out_byte      = ob;
      r.method_code   = (ph == PH_METHOD) ? METH_NONE : mcand;
      r.param_index   = (param_count != 0) ? 6'(param_count - 1) : 6'd0;
      r.path_length   = 9'(path_chars);
      r.err           = err;
      r.version_major = vmaj;
      r.version_minor = vmin;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         parsed_q.delete();
         clear_parser();
         backlog <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (parsed_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request waiting: expected none, got event %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = parsed_q.pop_front();
               check_field("event_res", want.ev, rsp_tuser);
               check_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               check_field("method_code", want.method_code, rsp_tdata[10:8]);
               check_field("param_index", want.param_index, rsp_tdata[16:11]);
               check_field("path_length", want.path_length, rsp_tdata[25:17]);
               check_field("error_code", want.err, rsp_tdata[28:26]);
               check_field("version_major", want.version_major, rsp_tdata[36:29]);
               check_field("version_minor", want.version_minor, rsp_tdata[44:37]);
               check_field("tdata padding", 0, rsp_tdata[47:45]);
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tuser, want);
            parsed_q.push_back(want);
         end
         backlog <= parsed_q.size();
      end
   end

endmodule

// File: sim/http_request_line_parser_core_tb.sv
// -----------------------------------------------------------------------------
// http_request_line_parser_core_tb
// Feeds request lines into the parser: a few hand-built lines, then random
// lines that are mostly well formed, under changing sender and receiver
// back-pressure. The checker beside the block predicts every response.
// -----------------------------------------------------------------------------
module http_request_line_parser_core_tb
   import hrlp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PATH       = 256;
   localparam int MAX_PARAMS     = 32;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef enum int {
      SHAPE_PLAIN,
      SHAPE_LONG_PATH,
      SHAPE_LONG_QUERY,
      SHAPE_MANY_PARAMS,
      SHAPE_NOISE
   } line_shape_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   int          fail_count;
   int          backlog;
   int          items_sent    = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_requests = 0;
   int          idle_cycles   = 0;
   logic [7:0]  line_q[$];

   string url_chars = "azAZ09m5Q/-._~";
   string hex_chars = "0123456789abcdefABCDEF";
   string key_chars = "azAZ09kv_~";

   http_request_line_parser_core #(
      .MAX_PATH   (MAX_PATH),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   http_request_line_parser_core_checker #(
      .MAX_PATH   (MAX_PATH),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here on demand.
   initial begin : receiver
      int hold_taken;
      int hold_left;
      hold_taken = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_req(input logic [7:0] ch, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_line();
      foreach (line_q[i]) begin
         send_req(line_q[i], i == 0);
      end
      line_q.delete();
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_q.push_back(s[i]);
      end
   endtask

   task automatic push_any();
      line_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic push_from(input string s);
      line_q.push_back(s[$urandom_range(s.len() - 1)]);
   endtask

   // Escape digits are mostly hex, but any byte may follow the percent sign.
   task automatic push_escape();
      line_q.push_back(CH_PERCENT);
      repeat (2) begin
         if ($urandom_range(99) < 75) begin
            push_from(hex_chars);
         end else begin
            push_any();
         end
      end
   endtask

   task automatic push_path_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 78) begin
         push_from(url_chars);
      end else if (roll < 92) begin
         push_escape();
      end else begin
         push_any();
      end
   endtask

   task automatic push_query_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         push_from(key_chars);
      end else if (roll < 80) begin
         push_escape();
      end else if (roll < 88) begin
         line_q.push_back(CH_EQUAL);
      end else if (roll < 93) begin
         line_q.push_back(CH_NUL);
      end else begin
         push_any();
      end
   endtask

   task automatic build_line(input line_shape_type shape);
      int         n;
      int         k;
      int         params;
      int         klen;
      logic [7:0] ver [8];
      line_q.delete();
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(1, 12)) push_any();
         return;
      end
      case ($urandom_range(4))
         0:       push_text("GET ");
         1:       push_text("PUT ");
         2:       push_text("POST ");
         3:       push_text("PATCH ");
         default: push_text("DELETE ");
      endcase
      if ($urandom_range(99) < 8) begin
         line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
      end
      n = (shape == SHAPE_LONG_PATH) ? $urandom_range(255, 260) : $urandom_range(0, 12);
      repeat (n) push_path_char();
      if (shape != SHAPE_PLAIN || $urandom_range(1) == 1) begin
         line_q.push_back(CH_QUESTION);
         case (shape)
            SHAPE_MANY_PARAMS: params = $urandom_range(MAX_PARAMS - 1, MAX_PARAMS + 2);
            SHAPE_LONG_QUERY:  params = 6;
            default:           params = $urandom_range(0, 4);
         endcase
         for (int i = 0; i < params; i++) begin
            if (i > 0) begin
               line_q.push_back(CH_AMP);
            end
            klen = (shape == SHAPE_LONG_QUERY) ? $urandom_range(40, 60) : $urandom_range(0, 4);
            repeat (klen) push_query_char();
            if ($urandom_range(99) < 70) begin
               line_q.push_back(CH_EQUAL);
               repeat ($urandom_range(0, 4)) push_query_char();
            end
         end
      end
      k = $urandom_range(99);
      if (k < 84) begin
         line_q.push_back(CH_SPACE);
      end else if (k < 92) begin
         line_q.push_back(CH_NUL);
      end else begin
         push_any();
      end
      ver = '{"H", "T", "T", "P", "/", "1", ".", "1"};
      ver[5] = ($urandom_range(99) < 85) ? 8'(CH_ZERO + $urandom_range(9))
                                          : 8'($urandom_range(255));
      ver[7] = ($urandom_range(99) < 85) ? 8'(CH_ZERO + $urandom_range(9))
                                          : 8'($urandom_range(255));
      if ($urandom_range(99) < 10) begin
         k = $urandom_range(5);
         ver[(k == 5) ? 6 : k] = 8'($urandom_range(255));
      end
      foreach (ver[i]) begin
         line_q.push_back(ver[i]);
      end
      repeat ($urandom_range(0, 2)) push_any();
      // Cut a few lines short so the next line start lands mid-parse.
      if ($urandom_range(99) < 5) begin
         n = $urandom_range(1, line_q.size());
         while (line_q.size() > n) begin
            void'(line_q.pop_back());
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   initial begin : stimulus
      int             base;
      int             line_no;
      int             mode;
      int             last_mode;
      line_shape_type shape;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Bad method, then idle bytes until the next line start.
      push_text("GXT");
      send_line();
      // NUL ends the path; then a bad version letter.
      push_text("PATCH /");
      line_q.push_back(CH_NUL);
      push_text("HTPP");
      send_line();
      // Unchecked hex digits, a space taken as a digit, then a bad path char.
      push_text("POST %zZ%");
      line_q.push_back(8'hFF);
      push_text(" $");
      send_line();
      // NUL as a key byte, a second '=' as value data, a non-digit major byte.
      push_text("PUT ?");
      line_q.push_back(CH_NUL);
      push_text("==& HTTP/");
      line_q.push_back(8'hFF);
      push_text(".9");
      send_line();
      push_text("DELETE /~?a=b HTTP/1.1");
      send_line();

      base      = items_sent;
      line_no   = 0;
      last_mode = 0;
      while (items_sent - base < RANDOM_ITEMS) begin
         mode = (items_sent - base) * 5 / RANDOM_ITEMS;
         if (mode != last_mode) begin
            last_mode = mode;
            if (mode == 2) begin
               drain();
            end
            case (mode)
               1: begin
                  send_idle_pct = 82;
                  stall_pct    <= 0;
               end
               2: begin
                  send_idle_pct = 0;
                  stall_pct    <= 82;
               end
               3: begin
                  send_idle_pct = 38;
                  stall_pct    <= 38;
               end
               default: begin
                  send_idle_pct = 0;
                  stall_pct    <= 0;
               end
            endcase
         end
         // Hold the receiver off early on while the sender keeps pushing.
         if (line_no == 0) begin
            hold_requests <= hold_requests + 1;
         end
         case (line_no)
            3:       shape = SHAPE_LONG_PATH;
            9:       shape = SHAPE_LONG_QUERY;
            15:      shape = SHAPE_MANY_PARAMS;
            default: begin
               mode  = $urandom_range(99);
               shape = (mode < 6) ? SHAPE_MANY_PARAMS : (mode < 16) ? SHAPE_NOISE : SHAPE_PLAIN;
            end
         endcase
         build_line(shape);
         send_line();
         line_no++;
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
